// ----- rtl/core/mlsm_pkg.sv -----
// Shared types and constants for the multi-linked stack manager.
// No dependencies; used by the interfaces, mlsm_core and the top level.
package mlsm_pkg;

   localparam int DATA_W = 8;
   localparam int SIDX_W = 4;
   // stack_index is zero-extended to this width before range checks
   localparam int SEL_W = 7;

   localparam int NUM_STACKS_DEF = 10;
   localparam int POOL_SIZE_DEF  = 64;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

endpackage

// ----- rtl/core/mlsm_ifs.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on mlsm_pkg for field widths and the operation code type.
interface mlsm_req_if;
   logic                         valid;
   logic                         ready;
   mlsm_pkg::func_type           func;
   logic [mlsm_pkg::SIDX_W-1:0]  stack_index;
   logic [mlsm_pkg::DATA_W-1:0]  push_data;

   modport source (output valid, func, stack_index, push_data, input ready);
   modport sink   (input valid, func, stack_index, push_data, output ready);
endinterface

interface mlsm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mlsm_pkg::DATA_W-1:0]  pop_data;
   logic                         success;

   modport source (output valid, pop_data, success, input ready);
   modport sink   (input valid, pop_data, success, output ready);
endinterface

// ----- rtl/core/mlsm_core.sv -----
// Stack state, per-stack top-of-stack cache and the shared node memory.
// Depends on mlsm_pkg. One operation per cycle when op_go is high.
module mlsm_core #(
   parameter int NUM_STACKS = mlsm_pkg::NUM_STACKS_DEF,
   parameter int POOL_SIZE  = mlsm_pkg::POOL_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_go,
   input  mlsm_pkg::func_type          op_func,
   input  logic [mlsm_pkg::SIDX_W-1:0] op_sidx,
   input  logic [mlsm_pkg::DATA_W-1:0] op_data,
   output logic [mlsm_pkg::DATA_W-1:0] res_pop_data,
   output logic                        res_success
);

   localparam int PW = $clog2(POOL_SIZE + 1);   // pointer incl. null
   localparam int IW = $clog2(POOL_SIZE);       // memory address
   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [PW-1:0] NIL = PW'(POOL_SIZE);
   localparam logic [mlsm_pkg::SEL_W-1:0] NSTK = mlsm_pkg::SEL_W'(NUM_STACKS);

   // per-stack head plus a copy of the top node's data and link
   logic [PW-1:0]               head_ff  [NUM_STACKS];
   logic [mlsm_pkg::DATA_W-1:0] tdata_ff [NUM_STACKS];
   logic [PW-1:0]               tnext_ff [NUM_STACKS];
   logic [PW-1:0]               free_head_ff;
   logic [PW-1:0]               free_next_ff;   // link of the free-list head node
   logic [PW-1:0]               fresh_ff;

   // refill read in flight: registered in rd_data_ff/rd_next_ff, then written into the cache
   logic                        pend_ff;
   logic                        pend_free_ff;
   logic [SW-1:0]               pend_stk_ff;

   logic [mlsm_pkg::DATA_W-1:0] mem_data [POOL_SIZE];
   logic [PW-1:0]               mem_next [POOL_SIZE];
   logic [mlsm_pkg::DATA_W-1:0] rd_data_ff;
   logic [PW-1:0]               rd_next_ff;

   logic [mlsm_pkg::SEL_W-1:0]  sel_ext;
   logic                        in_range;
   logic [SW-1:0]               sidx;
   logic [PW-1:0]               cur_head;
   logic [mlsm_pkg::DATA_W-1:0] cur_tdata;
   logic [PW-1:0]               cur_tnext;
   logic [PW-1:0]               cur_fnext;
   logic                        pend_hit;
   logic                        have_free;
   logic                        have_fresh;
   logic                        push_ok;
   logic                        pop_ok;
   logic [PW-1:0]               node;
   logic [IW-1:0]               raddr;
   logic [IW-1:0]               waddr;
   logic [PW-1:0]               wnext;

   assign sel_ext  = {{(mlsm_pkg::SEL_W - mlsm_pkg::SIDX_W){1'b0}}, op_sidx};
   assign in_range = sel_ext < NSTK;
   assign sidx     = in_range ? sel_ext[SW-1:0] : '0;

   // forward a refill that has just returned but is not yet in the cache
   assign pend_hit  = pend_ff && !pend_free_ff && (pend_stk_ff == sidx);
   assign cur_head  = head_ff[sidx];
   assign cur_tdata = pend_hit ? rd_data_ff : tdata_ff[sidx];
   assign cur_tnext = pend_hit ? rd_next_ff : tnext_ff[sidx];
   assign cur_fnext = (pend_ff && pend_free_ff) ? rd_next_ff : free_next_ff;

   assign have_free  = free_head_ff != NIL;
   assign have_fresh = fresh_ff != NIL;
   assign push_ok    = in_range && (op_func == mlsm_pkg::FUNC_PUSH) && (have_free || have_fresh);
   assign pop_ok     = in_range && (op_func == mlsm_pkg::FUNC_POP) && (cur_head != NIL);
   assign node       = have_free ? free_head_ff : fresh_ff;

   assign raddr = pop_ok ? cur_tnext[IW-1:0] : cur_fnext[IW-1:0];
   assign waddr = push_ok ? node[IW-1:0] : cur_head[IW-1:0];
   assign wnext = push_ok ? cur_head : free_head_ff;

   assign res_pop_data = pop_ok ? cur_tdata : '0;
   assign res_success  = push_ok || pop_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STACKS; s++) begin
            head_ff[s] <= NIL;
         end
         free_head_ff <= NIL;
         fresh_ff     <= '0;
         pend_ff      <= 1'b0;
      end else begin
         pend_ff <= 1'b0;
         if (pend_ff) begin
            if (pend_free_ff) begin
               free_next_ff <= rd_next_ff;
            end else begin
               tdata_ff[pend_stk_ff] <= rd_data_ff;
               tnext_ff[pend_stk_ff] <= rd_next_ff;
            end
         end
         if (op_go && push_ok) begin
            head_ff[sidx]  <= node;
            tdata_ff[sidx] <= op_data;
            tnext_ff[sidx] <= cur_head;
            if (have_free) begin
               free_head_ff <= cur_fnext;
               if (cur_fnext != NIL) begin
                  pend_ff      <= 1'b1;
                  pend_free_ff <= 1'b1;
               end
            end else begin
               fresh_ff <= fresh_ff + 1'b1;
            end
         end
         if (op_go && pop_ok) begin
            head_ff[sidx] <= cur_tnext;
            free_head_ff  <= cur_head;
            free_next_ff  <= free_head_ff;
            if (cur_tnext != NIL) begin
               pend_ff      <= 1'b1;
               pend_free_ff <= 1'b0;
               pend_stk_ff  <= sidx;
            end
         end
      end
   end

   // node memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (op_go && (push_ok || pop_ok)) begin
         mem_next[waddr] <= wnext;
      end
      if (op_go && push_ok) begin
         mem_data[waddr] <= op_data;
      end
      rd_data_ff <= mem_data[raddr];
      rd_next_ff <= mem_next[raddr];
   end

endmodule

// ----- rtl/core/multi_linked_stack_manager.sv -----
// Pipeline: the request beat is registered in s1; the core operation runs when the
// response register is free and its result is registered as the response beat.
// Throughput: one request per cycle unless rsp_chan stalls; a top-of-stack or free-list
// refill read of the node memory is forwarded to the next op in the cycle after issue.
// Reset: synchronous; empties all stacks and the free list, no memory clearing pass.
// Depends on mlsm_pkg, mlsm_ifs and mlsm_core.
module multi_linked_stack_manager #(
   parameter int NUM_STACKS = mlsm_pkg::NUM_STACKS_DEF,
   parameter int POOL_SIZE  = mlsm_pkg::POOL_SIZE_DEF
) (
   input logic        clock,
   input logic        reset,
   mlsm_req_if.sink   req_chan,
   mlsm_rsp_if.source rsp_chan
);

   logic                        s1_valid_ff;
   mlsm_pkg::func_type          s1_func_ff;
   logic [mlsm_pkg::SIDX_W-1:0] s1_sidx_ff;
   logic [mlsm_pkg::DATA_W-1:0] s1_data_ff;

   logic                        rsp_valid_ff;
   logic [mlsm_pkg::DATA_W-1:0] pop_data_ff;
   logic                        success_ff;

   logic                        res_free;
   logic                        s1_fire;
   logic                        req_beat;
   logic [mlsm_pkg::DATA_W-1:0] res_pop_data;
   logic                        res_success;

   assign res_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire  = s1_valid_ff && res_free;
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_beat = req_chan.valid && req_chan.ready;

   mlsm_core #(
      .NUM_STACKS(NUM_STACKS),
      .POOL_SIZE (POOL_SIZE)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .op_go       (s1_fire),
      .op_func     (s1_func_ff),
      .op_sidx     (s1_sidx_ff),
      .op_data     (s1_data_ff),
      .res_pop_data(res_pop_data),
      .res_success (res_success)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (res_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_func_ff <= req_chan.func;
         s1_sidx_ff <= req_chan.stack_index;
         s1_data_ff <= req_chan.push_data;
      end
      if (s1_fire) begin
         pop_data_ff <= res_pop_data;
         success_ff  <= res_success;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.pop_data = pop_data_ff;
   assign rsp_chan.success  = success_ff;

endmodule
